// ===== design/clr_pkg.sv =====
// Shared constants for the CPUID leaf responder: register map, leaf codes,
// fixed cache/TLB/size words and the built-in brand string.
// No dependencies.
package clr_pkg;

  localparam int unsigned BRAND_WORDS = 12;

  // Register map. Each register sits at byte offset 8*index.
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;
  localparam logic [2:0] REG_LEAF_LIMITS  = 3'd0;
  localparam logic [2:0] REG_CENTAUR_MAX  = 3'd1;
  localparam logic [2:0] REG_VERSION_SIG  = 3'd2;
  localparam logic [2:0] REG_STD_FEATURES = 3'd3;
  localparam logic [2:0] REG_EXT_FEATURES = 3'd4;
  localparam logic [2:0] REG_SVM_VIA      = 3'd5;
  localparam logic [2:0] REG_TOPO_VENDOR  = 3'd6;

  localparam logic [63:0] RST_LEAF_LIMITS = 64'h8000_000A_0000_0005;
  localparam logic [31:0] RST_VERSION_SIG = 32'h0001_06C2;
  localparam logic [24:0] RST_TOPO_VENDOR = 25'h000_0101;

  // Leaf codes
  localparam logic [31:0] LEAF_VENDOR     = 32'h0000_0000;
  localparam logic [31:0] LEAF_VERSION    = 32'h0000_0001;
  localparam logic [31:0] LEAF_CACHE_DESC = 32'h0000_0002;
  localparam logic [31:0] LEAF_CACHE_PARM = 32'h0000_0004;
  localparam logic [31:0] LEAF_MONITOR    = 32'h0000_0005;
  localparam logic [31:0] LEAF_EXT_MAX    = 32'h8000_0000;
  localparam logic [31:0] LEAF_EXT_FEAT   = 32'h8000_0001;
  localparam logic [31:0] LEAF_BRAND0     = 32'h8000_0002;
  localparam logic [31:0] LEAF_BRAND1     = 32'h8000_0003;
  localparam logic [31:0] LEAF_BRAND2     = 32'h8000_0004;
  localparam logic [31:0] LEAF_L1_INFO    = 32'h8000_0005;
  localparam logic [31:0] LEAF_L2_INFO    = 32'h8000_0006;
  localparam logic [31:0] LEAF_ADDR_SIZE  = 32'h8000_0008;
  localparam logic [31:0] LEAF_SVM        = 32'h8000_000A;
  localparam logic [31:0] LEAF_CENT_MAX   = 32'hC000_0000;
  localparam logic [31:0] LEAF_CENT_FEAT  = 32'hC000_0001;

  localparam logic [31:0] CENT_BASE = 32'hC000_0000;

  // Fixed answer words
  localparam logic [31:0] CACHE_DESC    = 32'h002c_307d;
  localparam logic [31:0] L1_EBX        = 32'h01c0_003f;
  localparam logic [31:0] L1_ECX        = 32'h0000_003f;
  localparam logic [31:0] L1D_EAX       = 32'h0000_0121;
  localparam logic [31:0] L1I_EAX       = 32'h0000_0122;
  localparam logic [31:0] L2_EAX        = 32'h0000_0143;
  localparam logic [31:0] L2_EBX        = 32'h03c0_003f;
  localparam logic [31:0] L2_SETS       = 32'h0000_0fff;
  localparam logic [31:0] L1_TLB        = 32'h01ff_01ff;
  localparam logic [31:0] L1_CACHE      = 32'h4002_0140;
  localparam logic [31:0] L2_TLB        = 32'h4200_4200;
  localparam logic [31:0] L2_CACHE      = 32'h0200_8140;
  localparam logic [31:0] ADDR_SIZE_LM  = 32'h0000_3028;
  localparam logic [31:0] ADDR_SIZE_PAE = 32'h0000_0024;
  localparam logic [31:0] ADDR_SIZE_32  = 32'h0000_0020;
  localparam logic [31:0] SVM_REV       = 32'h0000_0001;
  localparam logic [31:0] SVM_NASID     = 32'h0000_0010;
  localparam logic [31:0] MONITOR_ECX   = 32'h0000_0003;

  // Vendor strings, EBX / EDX / ECX
  localparam logic [31:0] AMD_B   = 32'h6874_7541;
  localparam logic [31:0] AMD_D   = 32'h6974_6e65;
  localparam logic [31:0] AMD_C   = 32'h444d_4163;
  localparam logic [31:0] INTEL_B = 32'h756e_6547;
  localparam logic [31:0] INTEL_D = 32'h4965_6e69;
  localparam logic [31:0] INTEL_C = 32'h6c65_746e;

  // "Virtual x86_64 CPU", little-endian, zero padded
  localparam logic [31:0] BRAND_ROM [BRAND_WORDS] = '{
    32'h7472_6956, 32'h206c_6175, 32'h5f36_3878, 32'h4320_3436,
    32'h0000_5550, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

endpackage

// ===== design/cpuid_leaf_responder_unit.sv =====
// CPUID leaf responder top level: configuration registers, request register,
// leaf clamp and answer decode, result register.
// Depends on clr_pkg.

// Answers one CPUID request (leaf, subleaf) per clock, unless out_ready stalls
// the result channel, with the four result words EAX/EBX/ECX/EDX. A request is
// held in the request register and then moves to the result register, where
// its result waits on the outputs until out_ready takes it; the two-stage
// pipeline takes a new request while the previous one is still in flight.
// Limits, signature, feature words and topology are set through the APB port
// (64-bit data, register i at byte offset 8*i) and should only be changed
// while no request is in flight.
module cpuid_leaf_responder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_leaf,
  input  logic [31:0] in_subleaf,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_a,
  output logic [31:0] out_result_b,
  output logic [31:0] out_result_c,
  output logic [31:0] out_result_d,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clr_pkg::PADDR_W-1:0] paddr,
  input  logic [clr_pkg::PDATA_W-1:0] pwdata,
  output logic [clr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  // configuration registers
  logic [63:0] leaf_limits_r;
  logic [31:0] centaur_max_r;
  logic [31:0] version_sig_r;
  logic [63:0] std_feat_r;
  logic [63:0] ext_feat_r;
  logic [63:0] svm_via_r;
  logic [24:0] topo_vendor_r;

  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[clr_pkg::PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_limits_r <= clr_pkg::RST_LEAF_LIMITS;
      centaur_max_r <= '0;
      version_sig_r <= clr_pkg::RST_VERSION_SIG;
      std_feat_r    <= '0;
      ext_feat_r    <= '0;
      svm_via_r     <= '0;
      topo_vendor_r <= clr_pkg::RST_TOPO_VENDOR;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        clr_pkg::REG_LEAF_LIMITS:  leaf_limits_r <= pwdata;
        clr_pkg::REG_CENTAUR_MAX:  centaur_max_r <= pwdata[31:0];
        clr_pkg::REG_VERSION_SIG:  version_sig_r <= pwdata[31:0];
        clr_pkg::REG_STD_FEATURES: std_feat_r    <= pwdata;
        clr_pkg::REG_EXT_FEATURES: ext_feat_r    <= pwdata;
        clr_pkg::REG_SVM_VIA:      svm_via_r     <= pwdata;
        clr_pkg::REG_TOPO_VENDOR:  topo_vendor_r <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      clr_pkg::REG_LEAF_LIMITS:  prdata = leaf_limits_r;
      clr_pkg::REG_CENTAUR_MAX:  prdata = {32'd0, centaur_max_r};
      clr_pkg::REG_VERSION_SIG:  prdata = {32'd0, version_sig_r};
      clr_pkg::REG_STD_FEATURES: prdata = std_feat_r;
      clr_pkg::REG_EXT_FEATURES: prdata = ext_feat_r;
      clr_pkg::REG_SVM_VIA:      prdata = svm_via_r;
      clr_pkg::REG_TOPO_VENDOR:  prdata = {39'd0, topo_vendor_r};
      default:                   prdata = '0;
    endcase
  end

  // pipeline control
  logic        s1_valid_r;
  logic [31:0] s1_leaf_r;
  logic [31:0] s1_sub_r;
  logic        s2_valid_r;
  logic [31:0] res_a_r, res_b_r, res_c_r, res_d_r;
  logic        s1_adv;

  assign s1_adv   = s1_valid_r & (~s2_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (~s2_valid_r | out_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready & in_valid) begin
      s1_leaf_r <= in_leaf;
      s1_sub_r  <= in_subleaf;
    end
  end

  // leaf clamp
  logic [31:0] basic, ext, leaf_c;

  assign basic = leaf_limits_r[31:0];
  assign ext   = leaf_limits_r[63:32];

  always_comb begin
    leaf_c = s1_leaf_r;
    if (s1_leaf_r[31]) begin
      if (s1_leaf_r > ext) begin
        if (centaur_max_r != '0) begin
          if (s1_leaf_r > centaur_max_r) begin
            leaf_c = centaur_max_r;
          end else if (s1_leaf_r < clr_pkg::CENT_BASE) begin
            leaf_c = ext;
          end
        end else begin
          leaf_c = ext;
        end
      end
    end else if (s1_leaf_r > basic) begin
      leaf_c = basic;
    end
  end

  // topology fields
  logic [7:0]  cores, threads, apic;
  logic [7:0]  cores_m1, threads_m1;
  logic [15:0] logical;
  logic        multi;
  logic        is_amd;
  logic [31:0] vend_b, vend_c, vend_d;

  assign cores      = topo_vendor_r[7:0];
  assign threads    = topo_vendor_r[15:8];
  assign apic       = topo_vendor_r[23:16];
  assign is_amd     = topo_vendor_r[24];
  assign cores_m1   = cores - 8'd1;
  assign threads_m1 = threads - 8'd1;
  assign logical    = cores * threads;
  assign multi      = logical > 16'd1;
  assign vend_b     = is_amd ? clr_pkg::AMD_B : clr_pkg::INTEL_B;
  assign vend_c     = is_amd ? clr_pkg::AMD_C : clr_pkg::INTEL_C;
  assign vend_d     = is_amd ? clr_pkg::AMD_D : clr_pkg::INTEL_D;

  // answer decode
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] core_field;

  assign core_field = (cores > 8'd1) ? {cores_m1[5:0], 26'd0} : '0;

  always_comb begin
    a_nxt = '0;
    b_nxt = '0;
    c_nxt = '0;
    d_nxt = '0;
    unique case (leaf_c)
      clr_pkg::LEAF_VENDOR: begin
        a_nxt = basic;
        b_nxt = vend_b;
        c_nxt = vend_c;
        d_nxt = vend_d;
      end
      clr_pkg::LEAF_VERSION: begin
        a_nxt = version_sig_r;
        b_nxt = {apic, 24'h00_0800};
        c_nxt = std_feat_r[63:32];
        d_nxt = std_feat_r[31:0];
        if (multi) begin
          b_nxt = b_nxt | {logical, 16'd0};
          d_nxt[28] = 1'b1;
        end
      end
      clr_pkg::LEAF_CACHE_DESC: begin
        a_nxt = 32'd1;
        d_nxt = clr_pkg::CACHE_DESC;
      end
      clr_pkg::LEAF_CACHE_PARM: begin
        if (s1_sub_r == 32'd0 || s1_sub_r == 32'd1) begin
          a_nxt = core_field | ((s1_sub_r == 32'd0) ? clr_pkg::L1D_EAX : clr_pkg::L1I_EAX);
          b_nxt = clr_pkg::L1_EBX;
          c_nxt = clr_pkg::L1_ECX;
          d_nxt = 32'd1;
        end else if (s1_sub_r == 32'd2) begin
          a_nxt = core_field | clr_pkg::L2_EAX;
          if (threads > 8'd1) begin
            a_nxt = a_nxt | {10'd0, threads_m1, 14'd0};
          end
          b_nxt = clr_pkg::L2_EBX;
          c_nxt = clr_pkg::L2_SETS;
          d_nxt = 32'd1;
        end
      end
      clr_pkg::LEAF_MONITOR: begin
        c_nxt = clr_pkg::MONITOR_ECX;
      end
      clr_pkg::LEAF_EXT_MAX: begin
        a_nxt = ext;
        b_nxt = vend_b;
        c_nxt = vend_c;
        d_nxt = vend_d;
      end
      clr_pkg::LEAF_EXT_FEAT: begin
        a_nxt = version_sig_r;
        c_nxt = ext_feat_r[63:32];
        d_nxt = ext_feat_r[31:0];
        if (multi & is_amd) begin
          c_nxt[1] = 1'b1;
        end
      end
      clr_pkg::LEAF_BRAND0: begin
        a_nxt = clr_pkg::BRAND_ROM[0];
        b_nxt = clr_pkg::BRAND_ROM[1];
        c_nxt = clr_pkg::BRAND_ROM[2];
        d_nxt = clr_pkg::BRAND_ROM[3];
      end
      clr_pkg::LEAF_BRAND1: begin
        a_nxt = clr_pkg::BRAND_ROM[4];
        b_nxt = clr_pkg::BRAND_ROM[5];
        c_nxt = clr_pkg::BRAND_ROM[6];
        d_nxt = clr_pkg::BRAND_ROM[7];
      end
      clr_pkg::LEAF_BRAND2: begin
        a_nxt = clr_pkg::BRAND_ROM[8];
        b_nxt = clr_pkg::BRAND_ROM[9];
        c_nxt = clr_pkg::BRAND_ROM[10];
        d_nxt = clr_pkg::BRAND_ROM[11];
      end
      clr_pkg::LEAF_L1_INFO: begin
        a_nxt = clr_pkg::L1_TLB;
        b_nxt = clr_pkg::L1_TLB;
        c_nxt = clr_pkg::L1_CACHE;
        d_nxt = clr_pkg::L1_CACHE;
      end
      clr_pkg::LEAF_L2_INFO: begin
        b_nxt = clr_pkg::L2_TLB;
        c_nxt = clr_pkg::L2_CACHE;
      end
      clr_pkg::LEAF_ADDR_SIZE: begin
        if (ext_feat_r[29]) begin
          a_nxt = clr_pkg::ADDR_SIZE_LM;
        end else if (std_feat_r[17]) begin
          a_nxt = clr_pkg::ADDR_SIZE_PAE;
        end else begin
          a_nxt = clr_pkg::ADDR_SIZE_32;
        end
        if (multi) begin
          c_nxt = {16'd0, logical - 16'd1};
        end
      end
      clr_pkg::LEAF_SVM: begin
        if (ext_feat_r[34]) begin
          a_nxt = clr_pkg::SVM_REV;
          b_nxt = clr_pkg::SVM_NASID;
          d_nxt = svm_via_r[31:0];
        end
      end
      clr_pkg::LEAF_CENT_MAX: begin
        a_nxt = centaur_max_r;
      end
      clr_pkg::LEAF_CENT_FEAT: begin
        a_nxt = version_sig_r;
        d_nxt = svm_via_r[63:32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_a_r <= a_nxt;
      res_b_r <= b_nxt;
      res_c_r <= c_nxt;
      res_d_r <= d_nxt;
    end
  end

  assign out_valid    = s2_valid_r;
  assign out_result_a = res_a_r;
  assign out_result_b = res_b_r;
  assign out_result_c = res_c_r;
  assign out_result_d = res_d_r;

endmodule

// ===== design/clr_checker.sv =====
// Port-level checks for the CPUID leaf responder, bound to the top level.
// Depends only on the top level's port names.
module clr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_a,
  input logic [31:0] out_result_b,
  input logic [31:0] out_result_c,
  input logic [31:0] out_result_d
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_a) &&
      $stable(out_result_b) && $stable(out_result_c) && $stable(out_result_d))
    else $error("stalled result changed");

  // an empty result stage always lets a request in
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty result stage");

  // a result leaving frees room for the next request
  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("request blocked while result drains");

endmodule

bind cpuid_leaf_responder_unit clr_checker u_clr_checker (.*);

// ===== tb/sv/cpuid_leaf_responder_unit_tb.sv =====
// Self-checking testbench for cpuid_leaf_responder_unit: drives CPUID requests under
// several register settings and compares every answer against an in-bench predictor.
// Depends on clr_pkg (register indexes and port widths) and the DUT.
`timescale 1ns / 1ps

module cpuid_leaf_responder_unit_tb;

  localparam int NUM_PHASES       = 8;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int HOLDOFF_AT       = 300;
  localparam int HOLDOFF_CYCLES   = 200;
  localparam int QUIET_LIMIT      = 5000;
  localparam int END_PAUSE        = 10;

  // leaf codes
  localparam logic [31:0] LF_VENDOR      = 32'h0000_0000;
  localparam logic [31:0] LF_VERSION     = 32'h0000_0001;
  localparam logic [31:0] LF_CACHE_DESC  = 32'h0000_0002;
  localparam logic [31:0] LF_RESERVED    = 32'h0000_0003;
  localparam logic [31:0] LF_CACHE_PARMS = 32'h0000_0004;
  localparam logic [31:0] LF_MONITOR     = 32'h0000_0005;
  localparam logic [31:0] LF_EXT_MAX     = 32'h8000_0000;
  localparam logic [31:0] LF_EXT_FEAT    = 32'h8000_0001;
  localparam logic [31:0] LF_BRAND0      = 32'h8000_0002;
  localparam logic [31:0] LF_BRAND1      = 32'h8000_0003;
  localparam logic [31:0] LF_BRAND2      = 32'h8000_0004;
  localparam logic [31:0] LF_L1_INFO     = 32'h8000_0005;
  localparam logic [31:0] LF_L2_INFO     = 32'h8000_0006;
  localparam logic [31:0] LF_EXT_RSVD    = 32'h8000_0007;
  localparam logic [31:0] LF_ADDR_SIZE   = 32'h8000_0008;
  localparam logic [31:0] LF_SVM         = 32'h8000_000A;
  localparam logic [31:0] LF_CENT_MAX    = 32'hC000_0000;
  localparam logic [31:0] LF_CENT_FEAT   = 32'hC000_0001;

  // answer words
  localparam logic [31:0] VND_AMD_B   = 32'h6874_7541;
  localparam logic [31:0] VND_AMD_C   = 32'h444d_4163;
  localparam logic [31:0] VND_AMD_D   = 32'h6974_6e65;
  localparam logic [31:0] VND_INTEL_B = 32'h756e_6547;
  localparam logic [31:0] VND_INTEL_C = 32'h6c65_746e;
  localparam logic [31:0] VND_INTEL_D = 32'h4965_6e69;
  localparam logic [31:0] CLFLUSH_WORD = 32'h0000_0800;
  localparam logic [31:0] HTT_FLAG     = 32'h1000_0000;
  localparam logic [31:0] MULTI_CORE_FLAG = 32'h0000_0002;
  localparam logic [31:0] DESC_COUNT   = 32'h0000_0001;
  localparam logic [31:0] DESC_WORD    = 32'h002c_307d;
  localparam logic [31:0] L1D_TYPE     = 32'h0000_0121;
  localparam logic [31:0] L1I_TYPE     = 32'h0000_0122;
  localparam logic [31:0] L2_TYPE      = 32'h0000_0143;
  localparam logic [31:0] L1_WAYS      = 32'h01c0_003f;
  localparam logic [31:0] L1_SETS      = 32'h0000_003f;
  localparam logic [31:0] L2_WAYS      = 32'h03c0_003f;
  localparam logic [31:0] L2_SETS_W    = 32'h0000_0fff;
  localparam logic [31:0] CACHE_FLAGS  = 32'h0000_0001;
  localparam logic [31:0] MWAIT_WORD   = 32'h0000_0003;
  localparam logic [31:0] TLB_L1       = 32'h01ff_01ff;
  localparam logic [31:0] CACHE_L1     = 32'h4002_0140;
  localparam logic [31:0] TLB_L2       = 32'h4200_4200;
  localparam logic [31:0] CACHE_L2     = 32'h0200_8140;
  localparam logic [31:0] ASZ_LONG     = 32'h0000_3028;
  localparam logic [31:0] ASZ_PSE36    = 32'h0000_0024;
  localparam logic [31:0] ASZ_FLAT     = 32'h0000_0020;
  localparam logic [31:0] SVM_REVISION = 32'h0000_0001;
  localparam logic [31:0] SVM_ASIDS    = 32'h0000_0010;
  localparam logic [31:0] CENT_START   = 32'hC000_0000;
  localparam int LM_BIT    = 29;
  localparam int PSE36_BIT = 17;
  localparam int SVM_BIT   = 2;

  localparam logic [31:0] BRAND_TEXT [12] = '{
    32'h7472_6956, 32'h206c_6175, 32'h5f36_3878, 32'h4320_3436,
    32'h0000_5550, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
  };

  typedef struct packed {
    logic [31:0] leaf;
    logic [31:0] subleaf;
  } request_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } answer_t;

  logic                         clk;
  logic                         rst_n      = 1'b0;
  logic                         in_valid   = 1'b0;
  logic                         in_ready;
  logic [31:0]                  in_leaf    = '0;
  logic [31:0]                  in_subleaf = '0;
  logic                         out_valid;
  logic                         out_ready  = 1'b0;
  logic [31:0]                  out_result_a;
  logic [31:0]                  out_result_b;
  logic [31:0]                  out_result_c;
  logic [31:0]                  out_result_d;
  logic                         psel       = 1'b0;
  logic                         penable    = 1'b0;
  logic                         pwrite     = 1'b0;
  logic [clr_pkg::PADDR_W-1:0]  paddr      = '0;
  logic [clr_pkg::PDATA_W-1:0]  pwdata     = '0;
  logic [clr_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // register shadow, reset values
  logic [63:0] cfg_limits   = 64'h8000_000A_0000_0005;
  logic [31:0] cfg_cent     = 32'h0;
  logic [31:0] cfg_sig      = 32'h0001_06C2;
  logic [63:0] cfg_std      = 64'h0;
  logic [63:0] cfg_ext      = 64'h0;
  logic [63:0] cfg_svm_via  = 64'h0;
  logic [24:0] cfg_topo     = 25'h101;

  request_t request_q[$];
  answer_t  answer_q[$];
  int       errors       = 0;
  int       results_seen = 0;
  int       in_idle_pct  = 20;
  int       out_idle_pct = 15;
  bit       calm         = 1'b0;
  int       quiet_cycles = 0;

  cpuid_leaf_responder_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_leaf     (in_leaf),
    .in_subleaf  (in_subleaf),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result_a(out_result_a),
    .out_result_b(out_result_b),
    .out_result_c(out_result_c),
    .out_result_d(out_result_d),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic answer_t cpuid_answer(logic [31:0] leaf, logic [31:0] sub);
    logic [31:0] basic, ext, f_edx, f_ecx, e2, e3, lf;
    logic [7:0]  cores, threads, apic;
    logic [15:0] logical;
    logic        amd;
    int          bi;
    answer_t     r;
    basic   = cfg_limits[31:0];
    ext     = cfg_limits[63:32];
    f_edx   = cfg_std[31:0];
    f_ecx   = cfg_std[63:32];
    e2      = cfg_ext[31:0];
    e3      = cfg_ext[63:32];
    cores   = cfg_topo[7:0];
    threads = cfg_topo[15:8];
    apic    = cfg_topo[23:16];
    amd     = cfg_topo[24];
    logical = cores * threads;
    r  = '0;
    lf = leaf;

    // clamp to the basic, extended or Centaur maximum
    if (lf[31]) begin
      if (lf > ext) begin
        if (cfg_cent != 32'h0) begin
          if (lf > cfg_cent) lf = cfg_cent;
          else if (lf < CENT_START) lf = ext;
        end else begin
          lf = ext;
        end
      end
    end else if (lf > basic) begin
      lf = basic;
    end

    case (lf)
      LF_VENDOR, LF_EXT_MAX: begin
        r.a = (lf == LF_VENDOR) ? basic : ext;
        if (amd) {r.b, r.c, r.d} = {VND_AMD_B, VND_AMD_C, VND_AMD_D};
        else     {r.b, r.c, r.d} = {VND_INTEL_B, VND_INTEL_C, VND_INTEL_D};
      end
      LF_VERSION: begin
        r.a = cfg_sig;
        r.b = {apic, 24'h0} | CLFLUSH_WORD;
        r.c = f_ecx;
        r.d = f_edx;
        if (logical > 16'd1) begin
          // logical count may spill into the APIC id byte
          r.b |= {logical, 16'h0};
          r.d |= HTT_FLAG;
        end
      end
      LF_CACHE_DESC: begin
        r.a = DESC_COUNT;
        r.d = DESC_WORD;
      end
      LF_CACHE_PARMS: begin
        if (cores > 8'd1) r.a = (32'(cores) - 32'd1) << 26;
        if (sub == 32'd0 || sub == 32'd1) begin
          r.a |= (sub == 32'd0) ? L1D_TYPE : L1I_TYPE;
          r.b = L1_WAYS;
          r.c = L1_SETS;
          r.d = CACHE_FLAGS;
        end else if (sub == 32'd2) begin
          r.a |= L2_TYPE;
          if (threads > 8'd1) r.a |= (32'(threads) - 32'd1) << 14;
          r.b = L2_WAYS;
          r.c = L2_SETS_W;
          r.d = CACHE_FLAGS;
        end else begin
          r.a = '0;
        end
      end
      LF_MONITOR: r.c = MWAIT_WORD;
      LF_EXT_FEAT: begin
        r.a = cfg_sig;
        r.c = e3;
        r.d = e2;
        if (logical > 16'd1 && amd) r.c |= MULTI_CORE_FLAG;
      end
      LF_BRAND0, LF_BRAND1, LF_BRAND2: begin
        bi  = int'(lf - LF_BRAND0) * 4;
        r.a = BRAND_TEXT[bi];
        r.b = BRAND_TEXT[bi + 1];
        r.c = BRAND_TEXT[bi + 2];
        r.d = BRAND_TEXT[bi + 3];
      end
      LF_L1_INFO: begin
        r.a = TLB_L1;
        r.b = TLB_L1;
        r.c = CACHE_L1;
        r.d = CACHE_L1;
      end
      LF_L2_INFO: begin
        r.b = TLB_L2;
        r.c = CACHE_L2;
      end
      LF_ADDR_SIZE: begin
        if (e2[LM_BIT]) r.a = ASZ_LONG;
        else r.a = f_edx[PSE36_BIT] ? ASZ_PSE36 : ASZ_FLAT;
        if (logical > 16'd1) r.c = 32'(logical) - 32'd1;
      end
      LF_SVM: begin
        if (e3[SVM_BIT]) begin
          r.a = SVM_REVISION;
          r.b = SVM_ASIDS;
          r.d = cfg_svm_via[31:0];
        end
      end
      LF_CENT_MAX: r.a = cfg_cent;
      LF_CENT_FEAT: begin
        r.a = cfg_sig;
        r.d = cfg_svm_via[63:32];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_word(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %h actual %h", field, want, got);
      errors++;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      clr_pkg::REG_LEAF_LIMITS:  cfg_limits  = value;
      clr_pkg::REG_CENTAUR_MAX:  cfg_cent    = value[31:0];
      clr_pkg::REG_VERSION_SIG:  cfg_sig     = value[31:0];
      clr_pkg::REG_STD_FEATURES: cfg_std     = value;
      clr_pkg::REG_EXT_FEATURES: cfg_ext     = value;
      clr_pkg::REG_SVM_VIA:      cfg_svm_via = value;
      clr_pkg::REG_TOPO_VENDOR:  cfg_topo    = value[24:0];
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    logic     next_valid;
    request_t req;
    int       in_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        answer_q.push_back(cpuid_answer(in_leaf, in_subleaf));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (request_q.size() != 0) begin
          if (!calm && $urandom_range(99) < in_idle_pct) begin
            in_gap = $urandom_range(15, 1) - 1;
          end else begin
            req        = request_q.pop_front();
            in_leaf    <= req.leaf;
            in_subleaf <= req.subleaf;
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : check_answers
    answer_t want;
    logic    next_ready;
    int      out_gap;
    int      hold_left;
    bit      holdoff_done;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      out_gap      = 0;
      hold_left    = 0;
      holdoff_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("answer with no request outstanding: %h %h %h %h",
                 out_result_a, out_result_b, out_result_c, out_result_d);
          errors++;
        end else begin
          want = answer_q.pop_front();
          compare_word("result_a", want.a, out_result_a);
          compare_word("result_b", want.b, out_result_b);
          compare_word("result_c", want.c, out_result_c);
          compare_word("result_d", want.d, out_result_d);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        // hold off long enough for the pipeline to back up into in_ready
        holdoff_done = 1'b1;
        hold_left    = HOLDOFF_CYCLES - 1;
        next_ready   = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        next_ready = 1'b0;
      end else if (!calm && $urandom_range(99) < out_idle_pct) begin
        out_gap    = $urandom_range(15, 1) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL cpuid_leaf_responder_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    request_t    req;
    logic [31:0] basic, ext, r_basic, r_ext, r_cent;
    logic [7:0]  cores, threads;
    int          pick;
    request_t    directed[$];

    directed = '{
      '{LF_VENDOR, 32'h0}, '{LF_VERSION, 32'hFFFF_FFFF}, '{LF_CACHE_DESC, 32'h0},
      '{LF_RESERVED, 32'h0}, '{LF_CACHE_PARMS, 32'h0}, '{LF_CACHE_PARMS, 32'h1},
      '{LF_CACHE_PARMS, 32'h2}, '{LF_CACHE_PARMS, 32'h3},
      '{LF_CACHE_PARMS, 32'hFFFF_FFFF}, '{LF_MONITOR, 32'h0},
      '{32'h0000_0006, 32'h0}, '{32'h7FFF_FFFF, 32'h2}, '{LF_EXT_MAX, 32'h0},
      '{LF_EXT_FEAT, 32'h0}, '{LF_BRAND0, 32'h0}, '{LF_BRAND1, 32'h0},
      '{LF_BRAND2, 32'h0}, '{LF_L1_INFO, 32'h0}, '{LF_L2_INFO, 32'h0},
      '{LF_EXT_RSVD, 32'h0}, '{LF_ADDR_SIZE, 32'h0}, '{32'h8000_0009, 32'h0},
      '{LF_SVM, 32'h0}, '{LF_CENT_MAX, 32'h0}, '{LF_CENT_FEAT, 32'h0},
      '{32'hFFFF_FFFF, 32'h0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // phase 0 runs on reset values; later phases reprogram every register
      if (phase == 1) begin
        write_reg(clr_pkg::REG_LEAF_LIMITS, 64'h0);
        write_reg(clr_pkg::REG_CENTAUR_MAX, 64'h0);
        write_reg(clr_pkg::REG_VERSION_SIG, 64'h0);
        write_reg(clr_pkg::REG_STD_FEATURES, 64'h0);
        write_reg(clr_pkg::REG_EXT_FEATURES, 64'h0);
        write_reg(clr_pkg::REG_SVM_VIA, 64'h0);
        write_reg(clr_pkg::REG_TOPO_VENDOR, 64'h0);
      end else if (phase == 2) begin
        write_reg(clr_pkg::REG_LEAF_LIMITS, '1);
        write_reg(clr_pkg::REG_CENTAUR_MAX, '1);
        write_reg(clr_pkg::REG_VERSION_SIG, '1);
        write_reg(clr_pkg::REG_STD_FEATURES, '1);
        write_reg(clr_pkg::REG_EXT_FEATURES, '1);
        write_reg(clr_pkg::REG_SVM_VIA, '1);
        write_reg(clr_pkg::REG_TOPO_VENDOR, '1);
      end else if (phase > 2) begin
        case ($urandom_range(3))
          0:       r_basic = $urandom_range(8);
          1:       r_basic = 32'h0000_0005;
          2:       r_basic = 32'hFFFF_FFFF;
          default: r_basic = $urandom;
        endcase
        case ($urandom_range(3))
          0:       r_ext = LF_EXT_MAX + $urandom_range(12);
          1:       r_ext = LF_SVM;
          2:       r_ext = $urandom_range(8);
          default: r_ext = $urandom;
        endcase
        case ($urandom_range(3))
          0:       r_cent = 32'h0;
          1:       r_cent = CENT_START + $urandom_range(2);
          2:       r_cent = 32'hFFFF_FFFF;
          default: r_cent = $urandom;
        endcase
        case ($urandom_range(3))
          0:       cores = 8'd1;
          1:       cores = 8'd255;
          default: cores = 8'($urandom_range(255));
        endcase
        case ($urandom_range(3))
          0:       threads = 8'd1;
          1:       threads = 8'd255;
          default: threads = 8'($urandom_range(255));
        endcase
        write_reg(clr_pkg::REG_LEAF_LIMITS, {r_ext, r_basic});
        write_reg(clr_pkg::REG_CENTAUR_MAX, {32'($urandom), r_cent});
        write_reg(clr_pkg::REG_VERSION_SIG, {32'($urandom), 32'($urandom)});
        write_reg(clr_pkg::REG_STD_FEATURES, {32'($urandom), 32'($urandom)});
        write_reg(clr_pkg::REG_EXT_FEATURES, {32'($urandom), 32'($urandom)});
        write_reg(clr_pkg::REG_SVM_VIA, {32'($urandom), 32'($urandom)});
        write_reg(clr_pkg::REG_TOPO_VENDOR,
                  {32'($urandom), 7'($urandom), 1'($urandom), 8'($urandom), threads, cores});
      end

      in_idle_pct  = (phase == 3) ? 0 : 20;
      out_idle_pct = (phase == 3) ? 0 : 15;
      calm         = (phase == NUM_PHASES - 1);

      if (phase == 0) begin
        foreach (directed[i]) request_q.push_back(directed[i]);
      end

      basic = cfg_limits[31:0];
      ext   = cfg_limits[63:32];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)      req.leaf = $urandom_range(7);
        else if (pick < 45) req.leaf = basic + $urandom_range(1);
        else if (pick < 75) req.leaf = LF_EXT_MAX + $urandom_range(12);
        else if (pick < 82) req.leaf = ext + $urandom_range(1);
        else if (pick < 90) req.leaf = CENT_START - 32'd2 + $urandom_range(5);
        else                req.leaf = $urandom;
        req.subleaf = ($urandom_range(99) < 60) ? 32'($urandom_range(3)) : 32'($urandom);
        request_q.push_back(req);
      end

      // drain before touching the registers again
      while (request_q.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
    end

    repeat (END_PAUSE) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d answers never arrived", answer_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS cpuid_leaf_responder_unit");
    end else begin
      $display("FAIL cpuid_leaf_responder_unit");
    end
    $finish;
  end

endmodule
